// ===== design/per_task_runtime_accounting_unit_defines.svh =====
// Assertion macros shared by the accounting unit RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PER_TASK_RUNTIME_ACCOUNTING_UNIT_DEFINES_SVH
`define PER_TASK_RUNTIME_ACCOUNTING_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PTRA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define PTRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PTRA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PTRA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/ptra_pkg.sv =====
// Types and constants for the per-task runtime accounting unit.
// No dependencies.
package ptra_pkg;

    localparam int unsigned TIME_W = 64;
    localparam int unsigned ID_W   = 10;

    typedef struct packed {
        logic [TIME_W-1:0] now_ns;
        logic [ID_W-1:0]   outgoing_task;
        logic [ID_W-1:0]   incoming_task;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]   charged_task;
        logic              was_charged;
        logic [TIME_W-1:0] slice_ns;
        logic [TIME_W-1:0] total_ns;
    } t_out_item;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_WRITE
    } t_state;

endpackage

// ===== design/ptra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptra_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/per_task_runtime_accounting_unit.sv =====
// Result path: the accepted beat and RAM reads are registered, the slice is registered
// in S_CALC and the result when S_WRITE advances, which waits while a result is held.
// A new event is taken only in S_IDLE; both RAMs are read in the accept cycle, the
// outgoing mark is cleared in S_CALC and both are written back in S_WRITE.
// Reset: synchronous, active low; afterwards a clearing pass over all 2**TASK_ID_BITS entries zeroes both RAMs,
// with input ready low until it ends. Depends on ptra_pkg, ptra_ram and per_task_runtime_accounting_unit_defines.svh.
`include "per_task_runtime_accounting_unit_defines.svh"

module per_task_runtime_accounting_unit #(
    parameter int unsigned TASK_ID_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ptra_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ptra_pkg::t_out_item o_out
);
    import ptra_pkg::*;

    localparam int unsigned DEPTH = 1 << TASK_ID_BITS;
    localparam int unsigned ST_W  = TIME_W + 1;

    t_state                  r_state, n_state;
    logic [TASK_ID_BITS-1:0] r_clr_idx;
    t_in_item                r_item;
    logic                    r_hit;
    logic [TIME_W-1:0]       r_slice;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    accept;
    logic                    advance;
    logic [TASK_ID_BITS-1:0] out_idx;
    logic [TASK_ID_BITS-1:0] in_idx;
    logic [TIME_W-1:0]       n_total;

    logic                    st_we, tot_we;
    logic [TASK_ID_BITS-1:0] st_waddr, tot_waddr;
    logic [ST_W-1:0]         st_wdata, st_rdata;
    logic [TIME_W-1:0]       tot_wdata, tot_rdata;

    assign out_idx = TASK_ID_BITS'(r_item.outgoing_task);
    assign in_idx  = TASK_ID_BITS'(r_item.incoming_task);
    assign accept  = i_in_valid && o_in_ready;
    assign advance = (r_state == S_WRITE) && (!r_out_valid || i_out_ready);
    assign n_total = tot_rdata + r_slice;

    // start mark: valid bit on top of the start timestamp
    ptra_ram #(.WIDTH(ST_W), .DEPTH(DEPTH)) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (accept),
        .i_raddr (TASK_ID_BITS'(i_in.outgoing_task)),
        .o_rdata (st_rdata)
    );

    ptra_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_total_ram (
        .i_clk   (i_clk),
        .i_we    (tot_we),
        .i_waddr (tot_waddr),
        .i_wdata (tot_wdata),
        .i_re    (accept),
        .i_raddr (TASK_ID_BITS'(i_in.outgoing_task)),
        .o_rdata (tot_rdata)
    );

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        st_we      = 1'b0;
        st_waddr   = out_idx;
        st_wdata   = '0;
        tot_we     = 1'b0;
        tot_waddr  = out_idx;
        tot_wdata  = n_total;
        case (r_state)
            S_CLEAR: begin
                st_we     = 1'b1;
                st_waddr  = r_clr_idx;
                tot_we    = 1'b1;
                tot_waddr = r_clr_idx;
                tot_wdata = '0;
                if (r_clr_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                // drop the outgoing mark before the incoming one is set
                st_we    = 1'b1;
                st_waddr = out_idx;
                st_wdata = {1'b0, r_item.now_ns};
                n_state  = S_WRITE;
            end
            S_WRITE: begin
                if (advance) begin
                    st_we    = 1'b1;
                    st_waddr = in_idx;
                    st_wdata = {1'b1, r_item.now_ns};
                    tot_we   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
        end
        if (r_state == S_CALC) begin
            r_hit   <= st_rdata[ST_W-1];
            r_slice <= st_rdata[ST_W-1] ? (r_item.now_ns - st_rdata[TIME_W-1:0]) : '0;
        end
        if (advance) begin
            r_out.charged_task <= r_item.outgoing_task;
            r_out.was_charged  <= r_hit;
            r_out.slice_ns     <= r_slice;
            r_out.total_ns     <= n_total;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `PTRA_ASSERT_IMPLIES(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_in_ready)
    `PTRA_ASSERT_NEXT(a_accept_to_calc, i_clk, i_rst_n, accept, r_state == S_CALC)
    `PTRA_ASSERT_IMPLIES(a_out_from_write, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_WRITE)
    `PTRA_ASSERT_IMPLIES(a_zero_slice, i_clk, i_rst_n, r_out_valid && !r_out.was_charged, r_out.slice_ns == '0)

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for per_task_runtime_accounting_unit: context-switch beats in,
// per-task charge reports out, checked against an in-bench accounting tracker.
// Depends on ptra_pkg and the accounting unit RTL.
module testbench;
    import ptra_pkg::*;

    localparam int          TASK_ID_BITS = 10;
    localparam int          TABLE_DEPTH  = 1 << TASK_ID_BITS;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    // Tracker state; bit arrays start out zero, matching the cleared tables.
    bit [TIME_W-1:0] mark_time [TABLE_DEPTH];
    bit              mark_set  [TABLE_DEPTH];
    bit [TIME_W-1:0] cpu_total [TABLE_DEPTH];

    t_out_item   pending_reports[$];
    t_out_item   want_rep;
    int unsigned n_errors    = 0;
    int unsigned cycle_count = 0;
    bit          src_idles   = 1'b1;
    bit          sink_stalls = 1'b1;

    // Scheduler view used to build well-formed switch sequences.
    logic [TIME_W-1:0] sched_now     = '0;
    logic [ID_W-1:0]   sched_running = '0;

    per_task_runtime_accounting_unit #(
        .TASK_ID_BITS(TASK_ID_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item account_switch(input t_in_item ev);
        t_out_item               rep;
        logic [TASK_ID_BITS-1:0] oi;
        logic [TASK_ID_BITS-1:0] ii;
        oi = TASK_ID_BITS'(ev.outgoing_task);
        ii = TASK_ID_BITS'(ev.incoming_task);
        rep.charged_task = ev.outgoing_task;
        rep.was_charged  = 1'b0;
        rep.slice_ns     = '0;
        if (mark_set[oi]) begin
            rep.slice_ns  = ev.now_ns - mark_time[oi];
            cpu_total[oi] = cpu_total[oi] + rep.slice_ns;
            mark_set[oi]  = 1'b0;
            rep.was_charged = 1'b1;
        end
        rep.total_ns = cpu_total[oi];
        // Charge first, then mark the incoming task.
        mark_time[ii] = ev.now_ns;
        mark_set[ii]  = 1'b1;
        return rep;
    endfunction

    // Check the result beat before queueing the new one: latency keeps them apart.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("result beat with no pending report, charged_task %0d",
                       o_out.charged_task);
                n_errors++;
            end else begin
                want_rep = pending_reports.pop_front();
                if (o_out.charged_task !== want_rep.charged_task) begin
                    $error("charged_task: expected %0d, got %0d",
                           want_rep.charged_task, o_out.charged_task);
                    n_errors++;
                end
                if (o_out.was_charged !== want_rep.was_charged) begin
                    $error("was_charged: expected %0d, got %0d",
                           want_rep.was_charged, o_out.was_charged);
                    n_errors++;
                end
                if (o_out.slice_ns !== want_rep.slice_ns) begin
                    $error("slice_ns: expected %h, got %h",
                           want_rep.slice_ns, o_out.slice_ns);
                    n_errors++;
                end
                if (o_out.total_ns !== want_rep.total_ns) begin
                    $error("total_ns: expected %h, got %h",
                           want_rep.total_ns, o_out.total_ns);
                    n_errors++;
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pending_reports.push_back(account_switch(i_in));
        end
    end

    always @(posedge i_clk) begin
        if (!sink_stalls) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 12);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_switch(input logic [TIME_W-1:0] now, input logic [ID_W-1:0] out_id,
                               input logic [ID_W-1:0] in_id);
        t_in_item ev;
        ev.now_ns        = now;
        ev.outgoing_task = out_id;
        ev.incoming_task = in_id;
        if (src_idles && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= ev;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain_reports();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        send_switch(64'd0, 10'd0, 10'd0);               // no mark yet
        send_switch(64'd100, 10'd0, 10'd1023);
        send_switch('1, 10'd1023, 10'd1023);            // same task out and in
        send_switch(64'd5, 10'd1023, 10'd512);          // clock went backwards
        send_switch(64'd4, 10'd512, 10'd512);           // slice of all ones
        send_switch(64'd6, 10'd512, 10'h2AA);           // total wraps
        send_switch(64'hAAAA_AAAA_AAAA_AAAA, 10'h155, 10'h155);
        send_switch(64'h5555_5555_5555_5555, 10'h155, 10'h2AA);
        send_switch(64'h5555_5555_5555_5556, 10'h2AA, 10'd1023);
        send_switch(64'd7, 10'd77, 10'd1);
        send_switch(64'd7, 10'd1, 10'd1);               // zero-length slice
        send_switch(64'd8, 10'd0, 10'd0);               // mark already cleared
        send_switch(64'd0, 10'd1023, 10'd0);
        sched_now     = 64'd0;
        sched_running = 10'd0;
    endtask

    // Mostly a scheduler switching among a small pool, with stray and odd events.
    task automatic test_random_schedule(input int n_events);
        logic [ID_W-1:0]   pool [16];
        logic [ID_W-1:0]   out_id;
        logic [ID_W-1:0]   in_id;
        logic [TIME_W-1:0] now;
        int unsigned       pick;
        foreach (pool[k]) pool[k] = ID_W'($urandom_range(0, 1023));
        pool[0] = sched_running;
        for (int i = 0; i < n_events; i++) begin
            pick   = $urandom_range(99);
            out_id = sched_running;
            in_id  = pool[4'($urandom_range(15))];
            now    = sched_now + TIME_W'($urandom_range(1, 100000));
            if (pick < 5) begin
                now = sched_now + {$urandom, $urandom};
            end else if (pick >= 80 && pick < 90) begin
                out_id = ID_W'($urandom_range(0, 1023));
                in_id  = ID_W'($urandom_range(0, 1023));
            end else if (pick >= 90 && pick < 95) begin
                now = sched_now - TIME_W'($urandom_range(0, 5000));
            end else if (pick >= 95) begin
                now = {$urandom, $urandom};
            end
            send_switch(now, out_id, in_id);
            sched_now     = now;
            sched_running = in_id;
        end
    endtask

    task automatic test_back_to_back();
        src_idles   = 1'b0;
        sink_stalls = 1'b0;
        test_random_schedule(200);
        src_idles   = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // Hold off new events until every report is back, several times.
    task automatic test_drain_pauses();
        for (int r = 0; r < 4; r++) begin
            test_random_schedule(30);
            drain_reports();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_back_to_back();
        test_drain_pauses();
        test_random_schedule(1000);
        drain_reports();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
